>>> rtl/iss_pkg.sv
// Shared types and constants for the insertion sorter.
// Used by iss_cell and insertion_sorter_unit; depends on nothing else.
package iss_pkg;

  // Number of cells in the chain, i.e. capacity of one set
  localparam int unsigned Depth = 16;
  // Fill count runs 0..Depth
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic ins;    // insert the broadcast value
    logic shift;  // move every entry one cell towards the head
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

endpackage

>>> rtl/insertion_sorter_unit.sv
// Top level of the insertion sorter: cell chain, fill counter, drain control.
// Depends on iss_pkg and iss_cell.
//
// Values enter one per cycle while in_stall_o is low and are placed in
// ascending order by a chain of iss_pkg::Depth cells, each comparing the
// incoming value with its own entry, so the cost of an insertion does not
// depend on the fill level. The item marked final_item is inserted too if
// the chain has room, then in_stall_o rises and the set is shifted out of
// the head cell, one result per cycle while out_stall_i is low, the last
// one flagged end_of_set. Results leave through the single output register.
// Values arriving at a full chain are dropped and every result of that set
// carries overflowed. No clearing pass is needed after reset.
module insertion_sorter_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  iss_pkg::data_t value_i,
  input  logic           final_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output iss_pkg::data_t sorted_value_o,
  output logic           end_of_set_o,
  output logic           overflowed_o
);

  localparam int unsigned Depth = iss_pkg::Depth;

  iss_pkg::state_e     state_q, state_d;
  iss_pkg::cnt_t       count_q, count_d;
  logic                drop_q, drop_d;
  logic                out_valid_q;
  iss_pkg::data_t      out_value_q;
  logic                out_last_q, out_ovf_q;
  iss_pkg::cell_ctrl_t ctrl;
  logic                in_acc, load, full, count_one;

  iss_pkg::data_t      cell_value [Depth];
  logic [Depth-1:0]    cell_less;
  logic [Depth-1:0]    cell_occ;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign full      = (count_q == iss_pkg::cnt_t'(Depth));
  assign count_one = (count_q == iss_pkg::cnt_t'(1));

  // Build the chain
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic           l_occ, l_less;
    iss_pkg::data_t l_value, r_value;

    assign cell_occ[i] = (count_q > iss_pkg::cnt_t'(i));

    if (i == 0) begin : g_head
      assign l_occ   = 1'b1;
      assign l_less  = 1'b0;
      assign l_value = value_i;
    end else begin : g_body
      assign l_occ   = cell_occ[i-1];
      assign l_less  = cell_less[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign r_value = cell_value[i];
    end else begin : g_inner
      assign r_value = cell_value[i+1];
    end

    iss_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_value_i  (value_i),
      .occ_i        (cell_occ[i]),
      .left_occ_i   (l_occ),
      .left_less_i  (l_less),
      .left_value_i (l_value),
      .right_value_i(r_value),
      .less_o       (cell_less[i]),
      .value_o      (cell_value[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iss_pkg::ST_FILL: begin
        if (in_acc && final_item_i) state_d = iss_pkg::ST_DRAIN;
      end
      iss_pkg::ST_DRAIN: begin
        if (load && count_one) state_d = iss_pkg::ST_FILL;
      end
      default: state_d = iss_pkg::ST_FILL;
    endcase
  end

  // Outputs of the control: handshake and chain command
  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    ctrl       = '0;
    case (state_q)
      iss_pkg::ST_FILL: begin
        in_stall_o = 1'b0;
        ctrl.ins   = in_acc && !full;
      end
      iss_pkg::ST_DRAIN: begin
        load       = !out_valid_q || !out_stall_i;
        ctrl.shift = load;
      end
      default: ;
    endcase
  end

  // Fill count and drop flag
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (ctrl.ins) count_d = count_q + iss_pkg::cnt_t'(1);
    if (in_acc && full) drop_d = 1'b1;
    if (load) begin
      count_d = count_q - iss_pkg::cnt_t'(1);
      if (count_one) drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iss_pkg::ST_FILL;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register: take the head entry of the chain
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q <= cell_value[0];
      out_last_q  <= count_one;
      out_ovf_q   <= drop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign end_of_set_o   = out_last_q;
  assign overflowed_o   = out_ovf_q;

`ifndef SYNTH
  // Fill count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iss_pkg::cnt_t'(Depth))
    else $error("fill count beyond capacity");

  // Draining always has an entry left to give out
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iss_pkg::ST_DRAIN |-> count_q != '0)
    else $error("drain with empty chain");

  // Insert and shift never share a cycle
  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.shift))
    else $error("insert and shift together");

  // A load always presents a transaction on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

  // Chain is empty once the last result of a set is loaded
  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && count_one |=> count_q == '0 && !drop_q)
    else $error("chain not emptied after set");
`endif

endmodule

>>> rtl/iss_cell.sv
// One cell of the sorting chain: holds one entry and compares it with the
// broadcast value. Depends on iss_pkg.
module iss_cell (
  input  logic                clk_i,
  input  iss_pkg::cell_ctrl_t ctrl_i,
  input  iss_pkg::data_t      new_value_i,
  input  logic                occ_i,        // this cell holds a live entry
  input  logic                left_occ_i,   // neighbour towards the head is live
  input  logic                left_less_i,  // neighbour towards the head moves up
  input  iss_pkg::data_t      left_value_i,
  input  iss_pkg::data_t      right_value_i,
  output logic                less_o,
  output iss_pkg::data_t      value_o
);

  iss_pkg::data_t value_q, value_d;

  // Strict compare keeps equal values in arrival order
  assign less_o  = occ_i && (new_value_i < value_q);
  assign value_o = value_q;

  // Make room for the new value, or take it, or drain towards the head
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (less_o || (left_occ_i && !occ_i)) begin
        value_d = left_less_i ? left_value_i : new_value_i;
      end
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> tb/insertion_sorter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter_unit: directed and random sets,
// each result checked against a sorting predictor held in a small class.
// Depends on iss_pkg and the insertion_sorter_unit RTL.
module insertion_sorter_unit_test;

  localparam int unsigned    Depth    = iss_pkg::Depth;
  localparam int unsigned    MaxGap   = 16;
  localparam int unsigned    LongHold = 300;
  localparam int unsigned    NumItems = 320;
  localparam iss_pkg::data_t MinVal   = 32'sh8000_0000;
  localparam iss_pkg::data_t MaxVal   = 32'sh7fff_ffff;

  // Tracks the set being collected and the sorted transactions still owed
  class sort_predictor;
    typedef struct {
      iss_pkg::data_t value;
      logic           last;
      logic           ovf;
    } sorted_out_t;

    iss_pkg::data_t held[$];
    bit             dropped;
    sorted_out_t    owed[$];
    int unsigned    mismatches;

    function void record_value(iss_pkg::data_t v, logic fin);
      int          pos;
      sorted_out_t entry;
      // Insert behind any equal entries, or drop when the set is full
      if (held.size() < Depth) begin
        pos = held.size();
        while (pos > 0 && v < held[pos-1]) pos--;
        held.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (fin) begin
        foreach (held[k]) begin
          entry.value = held[k];
          entry.last  = (k == held.size() - 1);
          entry.ovf   = dropped;
          owed.push_back(entry);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_sorted_out(iss_pkg::data_t v, logic eos, logic ovf);
      sorted_out_t exp_out;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d end %b ovf %b", v, eos, ovf);
      end else begin
        exp_out = owed.pop_front();
        if (v !== exp_out.value || eos !== exp_out.last || ovf !== exp_out.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: got value %0d end %b ovf %b, expected %0d end %b ovf %b",
                     v, eos, ovf, exp_out.value, exp_out.last, exp_out.ovf);
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  iss_pkg::data_t value_i;
  logic           final_item_i;
  logic           out_valid_o;
  logic           out_stall_i;
  iss_pkg::data_t sorted_value_o;
  logic           end_of_set_o;
  logic           overflowed_o;

  sort_predictor sorter_model;
  bit            sender_idles;
  bit            quiet;
  bit            long_hold_req;

  insertion_sorter_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .final_item_i   (final_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .end_of_set_o   (end_of_set_o),
    .overflowed_o   (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every accepted output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sorter_model.check_sorted_out(sorted_value_o, end_of_set_o, overflowed_o);
  end

  // Pick a value: mostly random patterns, with clusters of duplicates and extremes
  function automatic iss_pkg::data_t rand_value();
    case ($urandom_range(0, 4))
      0: return iss_pkg::data_t'($urandom_range(0, 8) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: return MinVal;
          1: return MaxVal;
          2: return iss_pkg::data_t'(0);
          default: return iss_pkg::data_t'(-1);
        endcase
      end
      default: return iss_pkg::data_t'($urandom());
    endcase
  endfunction

  // Offer one input transaction, after an optional idle burst, and hold until taken
  task automatic send_value(iss_pkg::data_t v, logic fin);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, MaxGap);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    final_item_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sorter_model.record_value(v, fin);
  endtask

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_value(rand_value(), i == n - 1);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i   <= 1'b1;
        span          = LongHold;
        long_hold_req = 1'b0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        span        = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        span        = $urandom_range(1, MaxGap);
      end else begin
        out_stall_i <= 1'b0;
        span        = $urandom_range(1, 24);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // Stimulus and end of run
  initial begin
    int items;
    int set_no;
    int n;
    int drain_wait;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    final_item_i  = 1'b0;
    sender_idles  = 1'b1;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    sorter_model  = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single-element set
    send_value(MinVal, 1'b1);
    // Extremes with a duplicate, arriving out of order
    send_value(MaxVal, 1'b0);
    send_value(iss_pkg::data_t'(0), 1'b0);
    send_value(iss_pkg::data_t'(-1), 1'b0);
    send_value(MinVal, 1'b0);
    send_value(iss_pkg::data_t'(0), 1'b0);
    send_value(iss_pkg::data_t'(1), 1'b1);
    // Overfilled set: the final value lands on a full store and is dropped
    for (int i = 0; i <= Depth; i++) begin
      if (i == Depth) send_value(MaxVal, 1'b1);
      else if (i % 2) send_value(iss_pkg::data_t'(-i), 1'b0);
      else send_value(iss_pkg::data_t'(Depth - i), 1'b0);
    end
    items = 24;

    // Random sets, mostly within capacity, some full, some overfilled
    set_no = 0;
    while (items < NumItems) begin
      case ($urandom_range(0, 9))
        0: n = Depth + $urandom_range(1, 4);
        1: n = Depth;
        2: n = 1;
        default: n = $urandom_range(2, Depth - 1);
      endcase
      if (set_no == 6) begin
        n             = Depth + 2;
        long_hold_req = 1'b1;
      end
      if (items > NumItems - 60) begin
        quiet        = 1'b1;
        sender_idles = 1'b0;
      end else begin
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      send_set(n);
      items += n;
      set_no++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain whatever is still owed, then allow a few quiet cycles
    drain_wait = 0;
    while (sorter_model.pending() != 0 && drain_wait < 10000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (2 * Depth + 4) @(posedge clk_i);
    if (sorter_model.mismatches == 0 && sorter_model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
rtl/iss_pkg.sv
rtl/iss_cell.sv
rtl/insertion_sorter_unit.sv
tb/insertion_sorter_unit_test.sv
